### rtl/core/charlieplexed_segment_scanner_assert.svh
// assertion macros for the segment scanner
`ifndef CHARLIEPLEXED_SEGMENT_SCANNER_ASSERT_SVH
`define CHARLIEPLEXED_SEGMENT_SCANNER_ASSERT_SVH

// same-cycle implication
`define CSS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("segment scanner check failed");

// next-cycle implication
`define CSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("segment scanner check failed");

`endif

### rtl/core/css_pkg.sv
// types, codes and lookup tables for the segment scanner
`timescale 1ns / 1ps
`default_nettype none
package css_pkg;

    localparam logic [1:0] MODE_NUMBER = 2'd0;
    localparam logic [1:0] MODE_DIGIT  = 2'd1;
    localparam logic [1:0] MODE_TEST   = 2'd2;

    localparam logic [7:0] NUM_MAX    = 8'd99;
    localparam logic [7:0] DIGIT_MAX  = 8'd9;
    localparam logic [1:0] PAIR_MAX   = 2'd1;
    localparam logic [1:0] SLOT_LAST  = 2'd3;
    localparam logic [2:0] SEG_LAST   = 3'd6;
    localparam logic [14:0] DIV10_MUL = 15'd205;
    localparam logic [6:0] RADIX      = 7'd10;

    typedef enum logic [0:0] {
        FS_TAKE,
        FS_TENS
    } t_front_state;

    typedef struct packed {
        logic       test;
        logic [1:0] slot;
        logic [3:0] digit;
        logic       last;
    } t_job;

    localparam logic [2:0] SEG_COUNT [10] = '{
        3'd6, 3'd2, 3'd5, 3'd5, 3'd4, 3'd5, 3'd6, 3'd3, 3'd7, 3'd6
    };

    localparam logic [2:0] SEG_LIST [10][7] = '{
        '{3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd0},
        '{3'd1, 3'd2, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0},
        '{3'd0, 3'd1, 3'd3, 3'd4, 3'd6, 3'd0, 3'd0},
        '{3'd0, 3'd1, 3'd2, 3'd3, 3'd6, 3'd0, 3'd0},
        '{3'd1, 3'd2, 3'd5, 3'd6, 3'd0, 3'd0, 3'd0},
        '{3'd0, 3'd2, 3'd3, 3'd5, 3'd6, 3'd0, 3'd0},
        '{3'd0, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd0},
        '{3'd0, 3'd1, 3'd2, 3'd0, 3'd0, 3'd0, 3'd0},
        '{3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6},
        '{3'd0, 3'd1, 3'd2, 3'd3, 3'd5, 3'd6, 3'd0}
    };

    // line driven high, zero based
    localparam logic [2:0] PAIR_HI [4][7] = '{
        '{3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd2},
        '{3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd1},
        '{3'd3, 3'd4, 3'd5, 3'd6, 3'd4, 3'd5, 3'd6},
        '{3'd2, 3'd2, 3'd2, 3'd2, 3'd3, 3'd3, 3'd3}
    };

    // line driven low, zero based
    localparam logic [2:0] PAIR_LO [4][7] = '{
        '{3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd1},
        '{3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd2},
        '{3'd2, 3'd2, 3'd2, 3'd2, 3'd3, 3'd3, 3'd3},
        '{3'd3, 3'd4, 3'd5, 3'd6, 3'd4, 3'd5, 3'd6}
    };

endpackage
`default_nettype wire

### rtl/core/css_if.sv
// request and result channel interfaces
`timescale 1ns / 1ps
`default_nettype none
interface css_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic [1:0] position;
    logic [7:0] value;

    modport source (output valid, mode, position, value, input ready);
    modport sink (input valid, mode, position, value, output ready);
endinterface

interface css_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] digit_slot;
    logic [2:0] segment;
    logic [6:0] line_drive;
    logic [6:0] line_level;
    logic       last;

    modport source (output valid, digit_slot, segment, line_drive, line_level, last,
                    input ready);
    modport sink (input valid, digit_slot, segment, line_drive, line_level, last,
                  output ready);
endinterface
`default_nettype wire

### rtl/core/css_front.sv
// request intake: checks the request and splits it into digit jobs
`timescale 1ns / 1ps
`default_nettype none
module css_front
    import css_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    css_in_if.sink     i_req,
    input  wire        i_full,
    output logic       o_push,
    output t_job       o_job
);

    t_front_state r_state;
    t_front_state n_state;
    t_job         r_tens_job;
    t_job         n_tens_job;

    logic [6:0]  w_val7;
    logic [14:0] w_prod;
    logic [3:0]  w_tens;
    logic [6:0]  w_tens_x10;
    logic [3:0]  w_units;
    logic        w_has_job;
    logic        w_split;
    t_job        w_job;
    logic        w_accept;

    // divide by ten for values up to 99
    always_comb begin
        w_val7     = i_req.value[6:0];
        w_prod     = 15'(w_val7) * DIV10_MUL;
        w_tens     = w_prod[14:11];
        w_tens_x10 = 7'(w_tens) * RADIX;
        w_units    = 4'(w_val7 - w_tens_x10);
    end

    always_comb begin
        w_has_job  = 1'b0;
        w_split    = 1'b0;
        w_job      = '0;
        n_tens_job = r_tens_job;
        case (i_req.mode)
            MODE_NUMBER: begin
                if (i_req.value <= NUM_MAX && i_req.position <= PAIR_MAX) begin
                    w_has_job        = 1'b1;
                    w_split          = 1'b1;
                    w_job.slot       = {i_req.position[0], 1'b1};
                    w_job.digit      = w_units;
                    w_job.last       = 1'b0;
                    n_tens_job.test  = 1'b0;
                    n_tens_job.slot  = {i_req.position[0], 1'b0};
                    n_tens_job.digit = w_tens;
                    n_tens_job.last  = 1'b1;
                end
            end
            MODE_DIGIT: begin
                if (i_req.value <= DIGIT_MAX) begin
                    w_has_job   = 1'b1;
                    w_job.slot  = i_req.position;
                    w_job.digit = i_req.value[3:0];
                    w_job.last  = 1'b1;
                end
            end
            MODE_TEST: begin
                w_has_job  = 1'b1;
                w_job.test = 1'b1;
                w_job.last = 1'b1;
            end
            default: begin
                w_has_job = 1'b0;
            end
        endcase
    end

    assign w_accept = i_req.valid && i_req.ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            FS_TAKE: begin
                if (w_accept && w_split) begin
                    n_state = FS_TENS;
                end
            end
            FS_TENS: begin
                if (!i_full) begin
                    n_state = FS_TAKE;
                end
            end
            default: begin
                n_state = FS_TAKE;
            end
        endcase
    end

    always_comb begin
        i_req.ready = 1'b0;
        o_push      = 1'b0;
        o_job       = w_job;
        case (r_state)
            FS_TAKE: begin
                i_req.ready = !i_full;
                o_push      = i_req.valid && !i_full && w_has_job;
                o_job       = w_job;
            end
            FS_TENS: begin
                i_req.ready = 1'b0;
                o_push      = !i_full;
                o_job       = r_tens_job;
            end
            default: begin
                i_req.ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FS_TAKE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_tens_job <= n_tens_job;
        end
    end

endmodule
`default_nettype wire

### rtl/core/css_queue.sv
// small job queue between intake and scan
`timescale 1ns / 1ps
`default_nettype none
module css_queue
    import css_pkg::*;
#(
    parameter int Depth = 4
) (
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_push,
    input  t_job  i_job,
    input  wire   i_pop,
    output t_job  o_job,
    output logic  o_full,
    output logic  o_empty
);

    localparam int PtrW = $clog2(Depth);
    localparam int CntW = $clog2(Depth + 1);
    localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
    localparam logic [CntW-1:0] CntFull = CntW'(Depth);

    t_job            r_mem [Depth];
    logic [PtrW-1:0] r_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr;
    logic [CntW-1:0] r_count;
    logic [PtrW-1:0] n_wr_ptr;
    logic [PtrW-1:0] n_rd_ptr;
    logic [CntW-1:0] n_count;

    assign o_full  = (r_count == CntFull);
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PtrLast) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PtrLast) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule
`default_nettype wire

### rtl/core/css_back.sv
// segment scan: walks one job's segments and registers each result
`timescale 1ns / 1ps
`default_nettype none
module css_back
    import css_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  t_job        i_job,
    input  wire         i_empty,
    output logic        o_pop,
    css_out_if.source   o_res
);

    logic       r_busy;
    t_job       r_job;
    logic [2:0] r_idx;
    logic [1:0] r_slot;
    logic [2:0] r_seg;
    logic       r_out_valid;
    logic [1:0] r_out_slot;
    logic [2:0] r_out_seg;
    logic [6:0] r_out_drive;
    logic [6:0] r_out_level;
    logic       r_out_last;

    logic       n_busy;
    t_job       n_job;
    logic [2:0] n_idx;
    logic [1:0] n_slot;
    logic [2:0] n_seg;
    logic       n_out_valid;

    logic       w_load;
    logic       w_emit;
    logic       w_end;
    logic [1:0] w_slot;
    logic [2:0] w_seg;
    logic [2:0] w_hi;
    logic [2:0] w_lo;

    assign w_load = !r_out_valid || o_res.ready;
    assign w_emit = r_busy && w_load;
    assign o_pop  = !r_busy && !i_empty;

    always_comb begin
        if (r_job.test) begin
            w_slot = r_slot;
            w_seg  = r_seg;
            w_end  = (r_slot == SLOT_LAST) && (r_seg == SEG_LAST);
        end else begin
            w_slot = r_job.slot;
            w_seg  = SEG_LIST[r_job.digit][r_idx];
            w_end  = (r_idx == SEG_COUNT[r_job.digit] - 3'd1);
        end
        w_hi = PAIR_HI[w_slot][w_seg];
        w_lo = PAIR_LO[w_slot][w_seg];
    end

    always_comb begin
        n_busy      = r_busy;
        n_job       = r_job;
        n_idx       = r_idx;
        n_slot      = r_slot;
        n_seg       = r_seg;
        n_out_valid = r_out_valid;
        if (w_load) begin
            n_out_valid = w_emit;
        end
        if (o_pop) begin
            n_busy = 1'b1;
            n_job  = i_job;
            n_idx  = '0;
            n_slot = '0;
            n_seg  = '0;
        end else if (w_emit) begin
            if (w_end) begin
                n_busy = 1'b0;
            end else if (r_job.test) begin
                if (r_seg == SEG_LAST) begin
                    n_seg  = '0;
                    n_slot = r_slot + 2'd1;
                end else begin
                    n_seg = r_seg + 3'd1;
                end
            end else begin
                n_idx = r_idx + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job  <= n_job;
        r_idx  <= n_idx;
        r_slot <= n_slot;
        r_seg  <= n_seg;
        if (w_emit) begin
            r_out_slot  <= w_slot;
            r_out_seg   <= w_seg;
            r_out_drive <= (7'b1 << w_hi) | (7'b1 << w_lo);
            r_out_level <= 7'b1 << w_hi;
            r_out_last  <= w_end && r_job.last;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.digit_slot = r_out_slot;
    assign o_res.segment    = r_out_seg;
    assign o_res.line_drive = r_out_drive;
    assign o_res.line_level = r_out_level;
    assign o_res.last       = r_out_last;

endmodule
`default_nettype wire

### rtl/core/charlieplexed_segment_scanner.sv
// flow: a taken request is split into digit jobs in the job queue; the scan unit registers each result
// throughput: one segment per cycle while o_res.ready allows, with a pause to load each queued job;
//   the scan unit sets the pace
// reset: synchronous active-low i_rst_n empties the job queue and drops output valid
`timescale 1ns / 1ps
`default_nettype none
`include "charlieplexed_segment_scanner_assert.svh"
module charlieplexed_segment_scanner
    import css_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    css_in_if.sink      i_req,
    css_out_if.source   o_res
);

    logic w_push;
    t_job w_push_job;
    logic w_pop;
    t_job w_pop_job;
    logic w_full;
    logic w_empty;

    css_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_job   (w_push_job)
    );

    css_queue #(
        .Depth (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .i_pop   (w_pop),
        .o_job   (w_pop_job),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    css_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (w_pop_job),
        .i_empty (w_empty),
        .o_pop   (w_pop),
        .o_res   (o_res)
    );

    `CSS_ASSERT_IMP(a_no_overflow, i_clk, i_rst_n, w_push, !w_full)
    `CSS_ASSERT_IMP(a_no_underflow, i_clk, i_rst_n, w_pop, !w_empty)
    `CSS_ASSERT_IMP(a_line_pair, i_clk, i_rst_n, o_res.valid, ($countones(o_res.line_drive) == 2 && $onehot(o_res.line_level) && ((o_res.line_level & ~o_res.line_drive) == 7'd0)))

endmodule
`default_nettype wire

### tb/charlieplexed_segment_scanner_tb.sv
// self-checking testbench for the charlieplexed segment scanner
`timescale 1ns / 1ps
module charlieplexed_segment_scanner_tb;
    import css_pkg::*;

    localparam logic [1:0] MODE_UNUSED  = 2'd3;
    localparam int         NUMBER_LIMIT = 99;
    localparam int         DIGIT_LIMIT  = 9;
    localparam int         PAIR_LIMIT   = 1;
    localparam int         RANDOM_ITEMS = 190;
    localparam int         HOLD_CYCLES  = 300;
    localparam int         TAIL_CYCLES  = 40;

    // {high line, low line} per segment, lines numbered from one, segment 0 in the top byte
    localparam logic [55:0] LINE_PAIRS [4] = '{
        56'h21_31_41_51_61_71_32,
        56'h12_13_14_15_16_17_23,
        56'h43_53_63_73_54_64_74,
        56'h34_35_36_37_45_46_47
    };

    // top nibble is the segment count, then the segments in lighting order
    localparam logic [31:0] DIGIT_SEGS [10] = '{
        32'h60123450, 32'h21200000, 32'h50134600, 32'h50123600, 32'h41256000,
        32'h50235600, 32'h60234560, 32'h30120000, 32'h70123456, 32'h60123560
    };

    typedef struct packed {
        logic [1:0] mode;
        logic [1:0] position;
        logic [7:0] value;
    } scan_req_t;

    typedef struct packed {
        logic [1:0] digit_slot;
        logic [2:0] segment;
        logic [6:0] line_drive;
        logic [6:0] line_level;
        logic       last;
    } lit_seg_t;

    logic i_clk;
    logic i_rst_n;

    css_in_if  req_if ();
    css_out_if res_if ();

    charlieplexed_segment_scanner u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_res   (res_if)
    );

    scan_req_t pending_requests [$];
    lit_seg_t  expected_segments [$];
    int        accepted_requests = 0;
    int        total_requests    = 0;
    int        mismatches        = 0;
    int        send_wait         = 0;
    int        send_calm         = 0;
    int        ready_wait        = 0;
    int        ready_calm        = 0;
    logic      req_taken         = 1'b0;
    logic      hold_off          = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #15_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic int pick_gap(inout int calm_left);
        int r;
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 5) begin
            calm_left = $urandom_range(20, 50);
            return 0;
        end
        if (r < 45) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(12, 40);
    endfunction

    function automatic void light_segment(input logic [1:0] slot, input logic [2:0] seg);
        logic [7:0] pair;
        int         hi;
        int         lo;
        lit_seg_t   s;
        pair         = LINE_PAIRS[slot][55 - 8 * int'(seg) -: 8];
        hi           = int'(pair[7:4]) - 1;
        lo           = int'(pair[3:0]) - 1;
        s.digit_slot = slot;
        s.segment    = seg;
        s.line_drive = 7'((1 << hi) | (1 << lo));
        s.line_level = 7'(1 << hi);
        s.last       = 1'b0;
        expected_segments.push_back(s);
    endfunction

    function automatic void light_digit(input logic [1:0] slot, input int d);
        logic [3:0] seg;
        if (d > DIGIT_LIMIT) return;
        for (int i = 0; i < int'(DIGIT_SEGS[d][31:28]); i++) begin
            seg = DIGIT_SEGS[d][27 - 4 * i -: 4];
            light_segment(slot, seg[2:0]);
        end
    endfunction

    function automatic void predict_scan(input scan_req_t req);
        int       prior_count;
        lit_seg_t tail;
        prior_count = expected_segments.size();
        case (req.mode)
            MODE_NUMBER: begin
                if (int'(req.value) <= NUMBER_LIMIT && int'(req.position) <= PAIR_LIMIT) begin
                    light_digit({req.position[0], 1'b1}, int'(req.value) % 10);
                    light_digit({req.position[0], 1'b0}, int'(req.value) / 10);
                end
            end
            MODE_DIGIT: light_digit(req.position, int'(req.value));
            MODE_TEST: begin
                for (int p = 0; p < 4; p++)
                    for (int g = 0; g < 7; g++)
                        light_segment(2'(p), 3'(g));
            end
            default: ;
        endcase
        if (expected_segments.size() > prior_count) begin
            tail      = expected_segments.pop_back();
            tail.last = 1'b1;
            expected_segments.push_back(tail);
        end
    endfunction

    task automatic report_mismatch(input string what, input lit_seg_t want,
                                   input lit_seg_t got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t %s: expected slot %0d seg %0d drive %b level %b last %b,",
                     $realtime, what, want.digit_slot, want.segment, want.line_drive,
                     want.line_level, want.last,
                     " got slot %0d seg %0d drive %b level %b last %b",
                     got.digit_slot, got.segment, got.line_drive, got.line_level,
                     got.last);
    endtask

    task automatic queue_request(input logic [1:0] mode, input logic [1:0] position,
                                 input logic [7:0] value);
        scan_req_t req;
        req.mode     = mode;
        req.position = position;
        req.value    = value;
        pending_requests.push_back(req);
        total_requests++;
    endtask

    // request driver
    always @(negedge i_clk) begin
        scan_req_t req;
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else if (!req_if.valid || req_taken) begin
            if (send_wait > 0) begin
                send_wait--;
                req_if.valid <= 1'b0;
            end else if (pending_requests.size() > 0) begin
                req = pending_requests.pop_front();
                req_if.mode     <= req.mode;
                req_if.position <= req.position;
                req_if.value    <= req.value;
                req_if.valid    <= 1'b1;
                send_wait = pick_gap(send_calm);
            end else begin
                req_if.valid <= 1'b0;
            end
        end
    end

    // result ready with random stalls
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else if (hold_off) begin
            res_if.ready <= 1'b0;
        end else if (ready_wait > 0) begin
            ready_wait--;
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) ready_wait = pick_gap(ready_calm);
        end
    end

    // monitor: predict on each request, check each result
    always @(posedge i_clk) begin : monitor
        scan_req_t req;
        lit_seg_t  got;
        lit_seg_t  want;
        if (!i_rst_n) begin
            req_taken <= 1'b0;
        end else begin
            req_taken <= req_if.valid && req_if.ready;
            if (req_if.valid && req_if.ready) begin
                req.mode     = req_if.mode;
                req.position = req_if.position;
                req.value    = req_if.value;
                predict_scan(req);
                accepted_requests++;
            end
            if (res_if.valid && res_if.ready) begin
                got.digit_slot = res_if.digit_slot;
                got.segment    = res_if.segment;
                got.line_drive = res_if.line_drive;
                got.line_level = res_if.line_level;
                got.last       = res_if.last;
                if (expected_segments.size() == 0) begin
                    report_mismatch("unexpected segment", '0, got);
                end else begin
                    want = expected_segments.pop_front();
                    if (got !== want) report_mismatch("segment mismatch", want, got);
                end
            end
        end
    end

    // long receiver hold-off so the request side backs up
    initial begin
        while (accepted_requests < 30) @(posedge i_clk);
        hold_off = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off = 1'b0;
    end

    initial begin
        int formed;
        int r;
        formed          = 0;
        i_rst_n         = 1'b0;
        req_if.valid    = 1'b0;
        req_if.mode     = MODE_NUMBER;
        req_if.position = 2'd0;
        req_if.value    = 8'd0;
        res_if.ready    = 1'b0;

        // number mode: leading zero, top value, out of range, bad pair index
        queue_request(MODE_NUMBER, 2'd0, 8'd0);
        queue_request(MODE_NUMBER, 2'd1, 8'd99);
        queue_request(MODE_NUMBER, 2'd0, 8'd100);
        queue_request(MODE_NUMBER, 2'd1, 8'd255);
        queue_request(MODE_NUMBER, 2'd2, 8'd45);
        queue_request(MODE_NUMBER, 2'd3, 8'd7);
        // every digit, every position, and out of range digits
        for (int d = 0; d <= DIGIT_LIMIT; d++)
            queue_request(MODE_DIGIT, 2'(d), 8'(d));
        queue_request(MODE_DIGIT, 2'd0, 8'd10);
        queue_request(MODE_DIGIT, 2'd3, 8'd255);
        // test sweep ignores position and value
        queue_request(MODE_TEST, 2'd0, 8'd0);
        queue_request(MODE_TEST, 2'd3, 8'd255);
        // unused mode
        queue_request(MODE_UNUSED, 2'd0, 8'd5);
        queue_request(MODE_UNUSED, 2'd3, 8'd255);

        while (formed < RANDOM_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 40) begin
                queue_request(MODE_NUMBER, 2'($urandom_range(0, PAIR_LIMIT)),
                              8'($urandom_range(0, NUMBER_LIMIT)));
                formed++;
            end else if (r < 75) begin
                queue_request(MODE_DIGIT, 2'($urandom_range(0, 3)),
                              8'($urandom_range(0, DIGIT_LIMIT)));
                formed++;
            end else if (r < 85) begin
                queue_request(MODE_TEST, 2'($urandom_range(0, 3)),
                              8'($urandom_range(0, 255)));
                formed++;
            end else begin
                queue_request(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                              8'($urandom_range(0, 255)));
            end
        end

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        while (accepted_requests < total_requests || expected_segments.size() > 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && expected_segments.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### files.f
+incdir+rtl/core
rtl/core/css_pkg.sv
rtl/core/css_if.sv
rtl/core/css_front.sv
rtl/core/css_queue.sv
rtl/core/css_back.sv
rtl/core/charlieplexed_segment_scanner.sv
tb/charlieplexed_segment_scanner_tb.sv
